[hdl/kvt_pkg.sv]
// Shared types, constants and elaboration helpers for the key/value table.
package kvt_pkg;

  localparam int DEF_CAPACITY   = 256;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;
  localparam int FIELD_BITS     = 32;
  localparam int IDX_W          = 13;
  localparam int RADIX_LOG      = 4;
  localparam int RADIX          = 1 << RADIX_LOG;

  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_UPDATE     = 3'd1,
    OP_INS_OR_UPD = 3'd2,
    OP_ERASE      = 3'd3,
    OP_LOOKUP     = 3'd4,
    OP_INDEX      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] req_key;
    logic [31:0] req_value;
    logic [8:0]  req_index;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] found_key;
    logic [31:0] found_value;
    logic [8:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic             cmp;
    logic             ins;
    logic             upd;
    logic             ers;
    logic [IDX_W-1:0] at;
  } cell_ctl_t;

  // nodes on tree level lvl for n leaves
  function automatic int tree_cnt(input int n, input int lvl);
    int c;
    c = n;
    for (int i = 0; i < lvl; i++) c = (c + RADIX - 1) >> RADIX_LOG;
    return c;
  endfunction

  function automatic int tree_levels(input int n);
    int lv;
    lv = 0;
    for (int i = 0; i < 32; i++) begin
      if (tree_cnt(n, lv) > 1) lv = lv + 1;
    end
    return lv;
  endfunction

  function automatic int tree_off(input int n, input int lvl);
    int o;
    o = 0;
    for (int i = 0; i < lvl; i++) o = o + tree_cnt(n, i);
    return o;
  endfunction

endpackage

[hdl/fixed_capacity_key_value_table.sv]
// Top level: request latch, sequencer, row of entry cells and result register.
// Each operation occupies the block from the start transfer to the next start
// transfer, in order: the request is latched, the key or index is compared in
// every cell at once, the levels of the registered 16-way tree collect the single
// matching entry one after another, and the change is applied to the cells. The
// result is shown for exactly one cycle, marked by out_valid, in the cycle in which
// busy falls; the receiver cannot stall it, so it must take the transfer in that
// cycle.
module fixed_capacity_key_value_table #(
  parameter int CAPACITY   = kvt_pkg::DEF_CAPACITY,
  parameter int KEY_BITS   = kvt_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = kvt_pkg::DEF_VALUE_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  kvt_pkg::req_t in_req,
  output logic          out_valid,
  output kvt_pkg::rsp_t out_rsp
);
  import kvt_pkg::*;

  localparam int KW = (KEY_BITS > FIELD_BITS) ? FIELD_BITS : KEY_BITS;
  localparam int VW = (VALUE_BITS > FIELD_BITS) ? FIELD_BITS : VALUE_BITS;
  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = 1 + PW + KW + VW;
  localparam int LV = tree_levels(CAPACITY);
  localparam int LCW = (LV > 1) ? $clog2(LV + 1) : 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t          state_r, state_nxt;
  req_t            req_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic [LCW-1:0]  lvl_r, lvl_nxt;
  logic            out_valid_r;
  rsp_t            out_rsp_r, rsp_nxt;
  cell_ctl_t       ctl;
  logic            accept;

  logic [KW-1:0]   cell_key [CAPACITY];
  logic [VW-1:0]   cell_val [CAPACITY];
  logic [RW-1:0]   contrib  [CAPACITY];
  logic [RW-1:0]   red;

  logic            red_hit;
  logic [PW-1:0]   red_pos;
  logic [KW-1:0]   red_key;
  logic [VW-1:0]   red_val;
  logic            full;
  logic            do_ins, do_upd, do_ers;

  assign accept = start && !busy;
  assign {red_hit, red_pos, red_key, red_val} = red;
  assign full = (count_r == CAP_C);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KW-1:0] nb_key;
    logic [VW-1:0] nb_val;
    if (i == CAPACITY - 1) begin : g_last
      assign nb_key = cell_key[i];
      assign nb_val = cell_val[i];
    end else begin : g_mid
      assign nb_key = cell_key[i+1];
      assign nb_val = cell_val[i+1];
    end
    kvt_cell #(.POS(i), .PW(PW), .KW(KW), .VW(VW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .req     (req_r),
      .count   (IDX_W'(count_r)),
      .ctl     (ctl),
      .nb_key  (nb_key),
      .nb_val  (nb_val),
      .key     (cell_key[i]),
      .val     (cell_val[i]),
      .contrib (contrib[i])
    );
  end

  kvt_or_tree #(.N(CAPACITY), .W(RW)) u_tree (
    .clk  (clk),
    .leaf (contrib),
    .root (red)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= (state_r == ST_APPLY);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_APPLY) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        lvl_nxt   = '0;
        state_nxt = (LV == 0) ? ST_APPLY : ST_RED;
      end
      ST_RED: begin
        lvl_nxt = lvl_r + 1'b1;
        if (lvl_r == LCW'(LV - 1)) state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // operation decode on the collected match
  always_comb begin
    do_ins = 1'b0;
    do_upd = 1'b0;
    do_ers = 1'b0;
    rsp_nxt = '0;
    case (req_r.req_type)
      OP_INSERT: begin
        do_ins = !red_hit && !full;
      end
      OP_UPDATE: begin
        do_upd = red_hit;
      end
      OP_INS_OR_UPD: begin
        do_upd = red_hit;
        do_ins = !red_hit && !full;
      end
      OP_ERASE: begin
        do_ers = red_hit;
      end
      OP_LOOKUP: begin
        rsp_nxt.ok          = red_hit;
        rsp_nxt.found_value = FIELD_BITS'(red_val);
      end
      OP_INDEX: begin
        rsp_nxt.ok          = red_hit;
        rsp_nxt.found_key   = FIELD_BITS'(red_key);
        rsp_nxt.found_value = FIELD_BITS'(red_val);
      end
      default: begin
        rsp_nxt.ok = 1'b0;
      end
    endcase
    if (state_r != ST_APPLY) begin
      do_ins = 1'b0;
      do_upd = 1'b0;
      do_ers = 1'b0;
    end
    if (do_ins || do_upd || do_ers) rsp_nxt.ok = 1'b1;
    count_nxt = count_r;
    if (do_ins) count_nxt = count_r + 1'b1;
    if (do_ers) count_nxt = count_r - 1'b1;
    rsp_nxt.entry_count = 9'(count_nxt);
  end

  // outputs
  always_comb begin
    busy    = (state_r != ST_IDLE);
    ctl.cmp = (state_r == ST_CMP);
    ctl.ins = do_ins;
    ctl.upd = do_upd;
    ctl.ers = do_ers;
    ctl.at  = do_ins ? IDX_W'(count_r) : IDX_W'(red_pos);
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

`ifndef SYNTH
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C) else $error("entry count above capacity");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("start transfer not followed by busy");

  a_count_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_APPLY) |=> (count_r == $past(count_r)))
    else $error("entry count changed outside apply");

  a_strobe_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_APPLY) |=> out_valid) else $error("missing result strobe");
`endif

endmodule

[hdl/kvt_cell.sv]
// One table entry: key/value storage, parallel match and neighbor shift on erase.
module kvt_cell #(
  parameter int POS = 0,
  parameter int PW  = 8,
  parameter int KW  = 32,
  parameter int VW  = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kvt_pkg::req_t             req,
  input  logic [kvt_pkg::IDX_W-1:0] count,
  input  kvt_pkg::cell_ctl_t        ctl,
  input  logic [KW-1:0]             nb_key,
  input  logic [VW-1:0]             nb_val,
  output logic [KW-1:0]             key,
  output logic [VW-1:0]             val,
  output logic [PW+KW+VW:0]         contrib
);
  import kvt_pkg::*;

  localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

  logic [KW-1:0]       key_r;
  logic [VW-1:0]       val_r;
  logic                hit_r;
  logic [PW+KW+VW:0]   contrib_r;
  logic                hit_c;
  logic                live;
  logic [KW-1:0]       key_in;
  logic [VW-1:0]       val_in;

  assign key_in = req.req_key[KW-1:0];
  assign val_in = req.req_value[VW-1:0];
  assign live   = MY_POS < count;

  always_comb begin
    hit_c = 1'b0;
    if (req.req_type inside {OP_INSERT, OP_UPDATE, OP_INS_OR_UPD, OP_ERASE, OP_LOOKUP}) begin
      hit_c = live && (key_r == key_in);
    end else if (req.req_type == OP_INDEX) begin
      hit_c = live && ({{(IDX_W-9){1'b0}}, req.req_index} == MY_POS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctl.cmp) begin
      hit_r <= hit_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      contrib_r <= hit_c ? {1'b1, PW'(POS), key_r, val_r} : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && (MY_POS == ctl.at)) begin
      key_r <= key_in;
      val_r <= val_in;
    end else if (ctl.upd && hit_r) begin
      val_r <= val_in;
    end else if (ctl.ers && (MY_POS >= ctl.at)) begin
      key_r <= nb_key;
      val_r <= nb_val;
    end
  end

  assign key     = key_r;
  assign val     = val_r;
  assign contrib = contrib_r;

endmodule

[hdl/kvt_or_tree.sv]
// Registered 16-way OR reduction tree over the one-hot cell results.
module kvt_or_tree #(
  parameter int N = 256,
  parameter int W = 8
) (
  input  logic         clk,
  input  logic [W-1:0] leaf [N],
  output logic [W-1:0] root
);
  import kvt_pkg::*;

  localparam int LV    = tree_levels(N);
  localparam int TOTAL = tree_off(N, LV + 1);

  logic [W-1:0] node [TOTAL];

  for (genvar j = 0; j < N; j++) begin : g_leaf
    assign node[j] = leaf[j];
  end

  for (genvar l = 1; l <= LV; l++) begin : g_lvl
    for (genvar j = 0; j < tree_cnt(N, l); j++) begin : g_node
      localparam int SRC = tree_off(N, l - 1) + j * RADIX;
      localparam int REM = tree_cnt(N, l - 1) - j * RADIX;
      localparam int NS  = (REM > RADIX) ? RADIX : REM;
      localparam int DST = tree_off(N, l) + j;
      logic [W-1:0] acc;
      logic [W-1:0] sum_r;
      always_comb begin
        acc = '0;
        for (int k = 0; k < NS; k++) acc = acc | node[SRC + k];
      end
      always_ff @(posedge clk) begin
        sum_r <= acc;
      end
      assign node[DST] = sum_r;
    end
  end

  assign root = node[TOTAL-1];

endmodule

[tb/tb_fixed_capacity_key_value_table.sv]
// Self-checking testbench for the key/value table: directed table, then random request streams.
`timescale 1ns / 1ps

module tb_fixed_capacity_key_value_table;
  import kvt_pkg::*;

  localparam int CAP = DEF_CAPACITY;
  localparam int TIW = $clog2(CAP);
  localparam int POOL_N = 20;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  typedef enum {MIX_OPS, FILL_UP, AT_CAPACITY, DRAIN} stim_mode_t;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  req_t in_req = '0;
  logic busy;
  logic out_valid;
  rsp_t out_rsp;

  bit   in_typed = 1'b0;
  rsp_t in_want = '0;

  logic [31:0] tbl_keys [CAP];
  logic [31:0] tbl_vals [CAP];
  int          tbl_count = 0;
  int          peak_count = 0;

  rsp_t        pending_rsp [$];
  dir_row_t    dir_rows [$];
  logic [31:0] key_pool [POOL_N];

  int mismatches = 0;
  int n_sent = 0;
  int n_rsp = 0;
  int n_ok = 0;
  int idle_pct = 0;

  fixed_capacity_key_value_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still pending", pending_rsp.size());
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: mismatch #%0d on %s: got %h, want %h", $realtime, mismatches, what, got,
             want);
  endtask

  function automatic rsp_t apply_table_op(input req_t r);
    rsp_t o;
    int   pos;
    o = '0;
    pos = tbl_count;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_keys[i] == r.req_key) begin
        pos = i;
        break;
      end
    end
    case (r.req_type)
      OP_INSERT: begin
        if (pos == tbl_count && tbl_count < CAP) begin
          tbl_keys[tbl_count] = r.req_key;
          tbl_vals[tbl_count] = r.req_value;
          tbl_count++;
          o.ok = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (pos < tbl_count) begin
          tbl_vals[pos] = r.req_value;
          o.ok = 1'b1;
        end
      end
      OP_INS_OR_UPD: begin
        if (pos < tbl_count) begin
          tbl_vals[pos] = r.req_value;
          o.ok = 1'b1;
        end else if (tbl_count < CAP) begin
          tbl_keys[tbl_count] = r.req_key;
          tbl_vals[tbl_count] = r.req_value;
          tbl_count++;
          o.ok = 1'b1;
        end
      end
      OP_ERASE: begin
        if (pos < tbl_count) begin
          for (int i = pos; i < tbl_count - 1; i++) begin
            tbl_keys[i] = tbl_keys[i + 1];
            tbl_vals[i] = tbl_vals[i + 1];
          end
          tbl_count--;
          o.ok = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (pos < tbl_count) begin
          o.found_value = tbl_vals[pos];
          o.ok = 1'b1;
        end
      end
      OP_INDEX: begin
        if (int'(r.req_index) < tbl_count) begin
          o.found_key = tbl_keys[TIW'(r.req_index)];
          o.found_value = tbl_vals[TIW'(r.req_index)];
          o.ok = 1'b1;
        end
      end
      default: ;
    endcase
    if (tbl_count > peak_count) peak_count = tbl_count;
    o.entry_count = 9'(tbl_count);
    return o;
  endfunction

  always @(posedge clk) begin : monitor
    rsp_t want;
    rsp_t got;
    if (rst_n) begin
      if (start && !busy) begin
        want = apply_table_op(in_req);
        if (in_typed) want = in_want;
        pending_rsp.push_back(want);
      end
      if (out_valid) begin
        got = out_rsp;
        n_rsp++;
        if (got.ok === 1'b1) n_ok++;
        if (pending_rsp.size() == 0) begin
          report_mismatch("result with nothing pending", 32'({got.ok, got.entry_count}), '0);
        end else begin
          want = pending_rsp.pop_front();
          if (got.ok !== want.ok) report_mismatch("ok", 32'(got.ok), 32'(want.ok));
          if (got.found_key !== want.found_key)
            report_mismatch("found_key", got.found_key, want.found_key);
          if (got.found_value !== want.found_value)
            report_mismatch("found_value", got.found_value, want.found_value);
          if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
        end
      end
    end
  end

  function automatic req_t mk_req(input logic [2:0] op, input logic [31:0] key,
                                  input logic [31:0] val, input logic [8:0] idx);
    req_t r;
    r.req_type = op;
    r.req_key = key;
    r.req_value = val;
    r.req_index = idx;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(input logic ok, input logic [31:0] key,
                                  input logic [31:0] val, input logic [8:0] cnt);
    rsp_t o;
    o.ok = ok;
    o.found_key = key;
    o.found_value = val;
    o.entry_count = cnt;
    return o;
  endfunction

  task automatic add_row(input req_t r, input bit typed, input rsp_t want);
    dir_row_t row;
    row.req = r;
    row.typed = typed;
    row.rsp = want;
    dir_rows.push_back(row);
  endtask

  function automatic logic [31:0] pick_live_key();
    if (tbl_count > 0) return tbl_keys[TIW'($urandom_range(tbl_count - 1))];
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_key();
    int w;
    w = $urandom_range(99);
    if (w < 45) return pick_live_key();
    if (w < 85) return key_pool[$urandom_range(POOL_N - 1)];
    return $urandom;
  endfunction

  function automatic logic [8:0] pick_index();
    int hi;
    hi = (tbl_count + 1 > 511) ? 511 : tbl_count + 1;
    if ($urandom_range(99) < 80) return 9'($urandom_range(hi));
    return 9'($urandom_range(511));
  endfunction

  function automatic req_t rand_req(input stim_mode_t mode);
    req_t r;
    int   w;
    r = mk_req(OP_LOOKUP, pick_key(), $urandom, 9'($urandom_range(511)));
    w = $urandom_range(99);
    case (mode)
      MIX_OPS: begin
        if (w < 20) r.req_type = OP_INSERT;
        else if (w < 35) r.req_type = OP_UPDATE;
        else if (w < 50) r.req_type = OP_INS_OR_UPD;
        else if (w < 65) r.req_type = OP_ERASE;
        else if (w < 80) r.req_type = OP_LOOKUP;
        else if (w < 95) r.req_type = OP_INDEX;
        else if (w < 97) r.req_type = OP_RSVD_6;
        else r.req_type = OP_RSVD_7;
        if (r.req_type == OP_INDEX && $urandom_range(3) != 0) r.req_index = pick_index();
      end
      FILL_UP: begin
        if (w < 65) begin
          r.req_type = OP_INSERT;
          r.req_key = $urandom;
        end else if (w < 90) begin
          r.req_type = OP_INS_OR_UPD;
          r.req_key = $urandom;
        end
      end
      AT_CAPACITY: begin
        if (w < 20) begin
          r.req_type = OP_INSERT;
          r.req_key = $urandom;
        end else if (w < 35) begin
          r.req_type = OP_INS_OR_UPD;
          r.req_key = $urandom;
        end else if (w < 50) begin
          r.req_type = OP_INS_OR_UPD;
          r.req_key = pick_live_key();
        end else if (w < 60) begin
          r.req_type = OP_UPDATE;
          r.req_key = pick_live_key();
        end else if (w < 70) begin
          r.req_key = pick_live_key();
        end else if (w < 88) begin
          r.req_type = OP_INDEX;
          case ($urandom_range(2))
            0: r.req_index = 9'(CAP - 1);
            1: r.req_index = 9'(CAP);
            default: r.req_index = pick_index();
          endcase
        end else begin
          r.req_type = OP_ERASE;
          r.req_key = pick_live_key();
        end
      end
      DRAIN: begin
        if (w < 75) begin
          r.req_type = OP_ERASE;
          r.req_key = pick_live_key();
        end else if (w < 85) begin
          r.req_type = OP_ERASE;
        end else if (w < 93) begin
          r.req_type = OP_INDEX;
          r.req_index = pick_index();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic issue(input req_t r, input bit typed, input rsp_t want);
    in_req <= r;
    in_typed <= typed;
    in_want <= want;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
    case ((n_sent / 100) % 4)
      0: idle_pct = 0;
      1: idle_pct = 67;
      2: idle_pct = 0;
      default: idle_pct = 37;
    endcase
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int   k;
    rsp_t leftover;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_N; i++) key_pool[i] = $urandom;

    add_row(mk_req(OP_LOOKUP, 32'h0, 32'h0, 9'h0), 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 9'd0));
    add_row(mk_req(OP_INDEX, 32'h0, 32'h0, 9'h0), 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 9'd0));
    add_row(mk_req(OP_UPDATE, 32'h1, 32'h5, 9'h0), 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 9'd0));
    add_row(mk_req(OP_ERASE, 32'h1, 32'h0, 9'h0), 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 9'd0));
    add_row(mk_req(OP_RSVD_6, 32'h0, 32'h9, 9'h0), 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 9'd0));
    add_row(mk_req(OP_RSVD_7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'h1FF), 1'b1,
            mk_rsp(1'b0, 32'h0, 32'h0, 9'd0));
    add_row(mk_req(OP_INSERT, 32'h0, 32'hFFFF_FFFF, 9'h1FF), 1'b1,
            mk_rsp(1'b1, 32'h0, 32'h0, 9'd1));
    add_row(mk_req(OP_INSERT, 32'hFFFF_FFFF, 32'h0, 9'h0), 1'b1,
            mk_rsp(1'b1, 32'h0, 32'h0, 9'd2));
    add_row(mk_req(OP_INSERT, 32'h0, 32'h1234_5678, 9'h0), 1'b1,
            mk_rsp(1'b0, 32'h0, 32'h0, 9'd2));
    add_row(mk_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 9'h0), 1'b0, '0);
    add_row(mk_req(OP_LOOKUP, 32'h0, 32'h0, 9'h0), 1'b0, '0);
    add_row(mk_req(OP_INDEX, 32'h0, 32'h0, 9'h1), 1'b0, '0);
    add_row(mk_req(OP_INDEX, 32'h0, 32'h0, 9'h1FF), 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 9'd2));
    add_row(mk_req(OP_INDEX, 32'h0, 32'h0, 9'h2), 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 9'd2));
    add_row(mk_req(OP_UPDATE, 32'h0, 32'h1234_5678, 9'h0), 1'b0, '0);
    add_row(mk_req(OP_INS_OR_UPD, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 9'h0), 1'b0, '0);
    add_row(mk_req(OP_INS_OR_UPD, 32'h5555_5555, 32'h5555_5555, 9'h0), 1'b0, '0);
    add_row(mk_req(OP_ERASE, 32'h0, 32'h0, 9'h0), 1'b0, '0);
    add_row(mk_req(OP_INDEX, 32'h0, 32'h0, 9'h0), 1'b0, '0);
    add_row(mk_req(OP_INDEX, 32'h0, 32'h0, 9'h1), 1'b0, '0);
    add_row(mk_req(OP_ERASE, 32'hFFFF_FFFF, 32'h0, 9'h0), 1'b0, '0);
    add_row(mk_req(OP_LOOKUP, 32'h0001_2345, 32'h0, 9'h0), 1'b1,
            mk_rsp(1'b0, 32'h0, 32'h0, 9'd1));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

    repeat (350) issue(rand_req(MIX_OPS), 1'b0, '0);
    k = 0;
    while (tbl_count < CAP && k < 420) begin
      issue(rand_req(FILL_UP), 1'b0, '0);
      k++;
    end
    repeat (80) issue(rand_req(AT_CAPACITY), 1'b0, '0);
    k = 0;
    while (tbl_count > 0 && k < 420) begin
      issue(rand_req(DRAIN), 1'b0, '0);
      k++;
    end
    repeat (250) issue(rand_req(MIX_OPS), 1'b0, '0);
    start <= 1'b0;

    k = 0;
    do begin
      @(posedge clk);
      k++;
    end while (pending_rsp.size() != 0 && k < 2000);
    repeat (10) @(posedge clk);
    while (pending_rsp.size() != 0) begin
      leftover = pending_rsp.pop_front();
      report_mismatch("missing result", 32'({leftover.ok, leftover.entry_count}), '0);
    end

    $display("covered %0d requests and %0d results, %0d of them successful", n_sent, n_rsp,
             n_ok);
    $display("occupancy ranged from empty up to %0d of %0d entries", peak_count, CAP);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[fixed_capacity_key_value_table.f]
hdl/kvt_pkg.sv
hdl/kvt_cell.sv
hdl/kvt_or_tree.sv
hdl/fixed_capacity_key_value_table.sv
tb/tb_fixed_capacity_key_value_table.sv
